// ===== src/linked_block_chain_allocator_unit_assert.svh =====
// Assertion macros for the linked block chain allocator.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef LINKED_BLOCK_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH
`define LINKED_BLOCK_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define LBCA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define LBCA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lbca_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// linked block chain allocator. No dependencies.
package lbca_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int BLOCK_COUNT = 128;
  localparam int BLOCK_BYTES = 512;

  localparam int KIND_W   = 2;
  localparam int FILE_W   = 4;
  localparam int SIZE_W   = 17;
  localparam int POS_W    = 16;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int OFS_W  = $clog2(BLOCK_BYTES);
  localparam int HOP_W  = SIZE_W - OFS_W + 1;

  localparam int LANES       = 8;
  localparam int LANE_W      = $clog2(LANES);
  localparam int GROUP_COUNT = (BLOCK_COUNT + LANES - 1) / LANES;
  localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PAD_COUNT   = GROUP_COUNT * LANES;

  localparam int BYTE_ADDR_W = BLK_W + OFS_W;
  localparam int BYTE_DEPTH  = BLOCK_COUNT * BLOCK_BYTES;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_SETSZ = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SLOT  = 2'd1,
    STATUS_NO_BLOCK = 2'd2,
    STATUS_BEYOND   = 2'd3
  } status_e;

  typedef struct packed {
    logic    load;
    logic    cur_first;
    logic    cnt_links;
    logic    cnt_hops;
    logic    scan_start;
    logic    scan_step;
    logic    alloc_commit;
    logic    append;
    logic    follow;
    logic    cut_start;
    logic    cut_hop;
    logic    cut_free;
    logic    cut_end;
    logic    byte_store;
    logic    set_status;
    status_e status;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              slot_ok;
    logic              slot_free;
    logic              scan_found;
    logic              scan_last;
    logic              cnt_zero;
    logic              cur_end;
    logic              cut_stop;
    logic              out_busy;
  } ctl_sts_t;

endpackage

// ===== src/linked_block_chain_allocator_unit.sv =====
// Top level of the linked block chain allocator: FAT-style file slots and
// block chains. Depends on lbca_pkg, lbca_ctrl, lbca_datapath and the
// assertion header.
//
//   channel  direction  tdata (low bit up)                        tuser
//   s_axis   in         file_index, size_bytes, position, data   kind
//   m_axis   out        result_file, status                       -
//
// One command at a time. Allocate reports no slot when no slot is free and
// otherwise scans for a free block (the free-block scanner checks eight
// blocks per cycle). Set size and write byte walk the chain link by link
// (registered read of the link memory); set size also scans for a free block
// for each appended block, and frees the blocks cut from the tail one by one.
// Reset clears the slot, used and chain-end flags at once; no clearing pass.
// A finished result waits in the output register while the next beat is
// accepted; an m_axis stall holds the next command in its last cycle until
// that register drains.
`include "linked_block_chain_allocator_unit_assert.svh"

module linked_block_chain_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // file_index[3:0], size_bytes[20:4], position[36:21], data_byte[44:37]
  input  logic [lbca_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind[1:0]
  input  logic [lbca_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_file[3:0], status[5:4]
  output logic [lbca_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import lbca_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer: decides every table update and walk step
  lbca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables, memories, scanner and output register
  lbca_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata)
  );

  // a command holds the sequencer until its result is handed off
  `LBCA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")

  // never overwrite a result that is still stalled
  `LBCA_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(m_axis_tvalid && !m_axis_tready), "overwrite")

  // each load of the result register shows a valid beat next cycle
  `LBCA_ASSERT_NEXT(a_load_shows, cmd.out_load, m_axis_tvalid, "loaded result not presented")

endmodule

// ===== src/lbca_ctrl.sv =====
// Controller state machine of the chain allocator: sequences table scans,
// chain walks and the result hand-off. Depends on lbca_pkg.
module lbca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lbca_pkg::ctl_sts_t sts_i,
  output lbca_pkg::ctl_cmd_t cmd_o
);
  import lbca_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DISP  = 12'b000000000010,
    S_ASCAN = 12'b000000000100,
    S_SCHK  = 12'b000000001000,
    S_SLINK = 12'b000000010000,
    S_SSCAN = 12'b000000100000,
    S_CSTRT = 12'b000001000000,
    S_CHOP  = 12'b000010000000,
    S_CFREE = 12'b000100000000,
    S_WCHK  = 12'b001000000000,
    S_WLINK = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.kind)
          KIND_ALLOC: begin
            if (!sts_i.slot_free) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STATUS_NO_SLOT;
              state_d          = S_DONE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_ASCAN;
            end
          end
          KIND_SETSZ, KIND_WRITE: begin
            if (!sts_i.slot_ok) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STATUS_BEYOND;
              state_d          = S_DONE;
            end else begin
              cmd_o.cur_first = 1'b1;
              if (sts_i.kind == KIND_SETSZ) begin
                cmd_o.cnt_links = 1'b1;
                state_d         = S_SCHK;
              end else begin
                cmd_o.cnt_hops = 1'b1;
                state_d        = S_WCHK;
              end
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ASCAN: begin
        if (sts_i.scan_found) begin
          cmd_o.alloc_commit = 1'b1;
          state_d            = S_DONE;
        end else if (sts_i.scan_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_NO_BLOCK;
          state_d          = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SCHK: begin
        if (sts_i.cnt_zero) begin
          state_d = S_CSTRT;
        end else if (sts_i.cur_end) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SSCAN;
        end else begin
          state_d = S_SLINK;
        end
      end
      S_SLINK: begin
        cmd_o.follow = 1'b1;
        state_d      = S_SCHK;
      end
      S_SSCAN: begin
        if (sts_i.scan_found) begin
          cmd_o.append = 1'b1;
          state_d      = S_SCHK;
        end else if (sts_i.scan_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_NO_BLOCK;
          state_d          = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_CSTRT: begin
        // a block that already ends the chain has no tail to free
        if (sts_i.cur_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.cut_start = 1'b1;
          state_d         = S_CHOP;
        end
      end
      S_CHOP: begin
        cmd_o.cut_hop = 1'b1;
        state_d       = S_CFREE;
      end
      S_CFREE: begin
        cmd_o.cut_free = 1'b1;
        if (sts_i.cut_stop) begin
          cmd_o.cut_end = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_CHOP;
        end
      end
      S_WCHK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.byte_store = 1'b1;
          state_d          = S_DONE;
        end else if (sts_i.cur_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STATUS_BEYOND;
          state_d          = S_DONE;
        end else begin
          state_d = S_WLINK;
        end
      end
      S_WLINK: begin
        cmd_o.follow = 1'b1;
        state_d      = S_WCHK;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== src/lbca_datapath.sv =====
// Datapath of the chain allocator: slot and block tables, link memory, byte
// store, free-block scanner and the result register. Depends on lbca_pkg.
module lbca_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lbca_pkg::ctl_cmd_t                  cmd_i,
  output lbca_pkg::ctl_sts_t                  sts_o,
  input  logic [lbca_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  logic [lbca_pkg::KIND_W-1:0]         in_tuser_i,
  output logic                                out_tvalid_o,
  input  logic                                out_tready_i,
  output logic [lbca_pkg::OUT_TDATA_W-1:0]    out_tdata_o
);
  import lbca_pkg::*;

  logic [KIND_W-1:0]  kind_q;
  logic [FILE_W-1:0]  file_q;
  logic [SIZE_W-1:0]  size_q;
  logic [POS_W-1:0]   pos_q;
  logic [DATA_W-1:0]  data_q;

  logic [SLOT_COUNT-1:0]  slot_valid_q;
  logic [BLK_W-1:0]       first_q [SLOT_COUNT];
  logic [BLOCK_COUNT-1:0] used_q;
  logic [BLOCK_COUNT-1:0] end_q;

  logic [BLK_W-1:0]  link_mem [BLOCK_COUNT];
  logic [BLK_W-1:0]  link_rd_q;
  logic [DATA_W-1:0] byte_mem [BYTE_DEPTH];

  logic [BLK_W-1:0]  cur_q;
  logic [BLK_W-1:0]  blk_q;
  logic [HOP_W-1:0]  cnt_q;
  logic [GRP_W-1:0]  grp_q;
  logic [FILE_W-1:0] res_q;
  status_e           status_q;

  logic              out_valid_q;
  logic [FILE_W-1:0] out_file_q;
  status_e           out_status_q;

  logic [SLOT_W-1:0]    slot_idx;
  logic                 slot_in_range;
  logic [SLOT_W-1:0]    free_slot;
  logic                 free_slot_found;
  logic [PAD_COUNT-1:0] used_pad;
  logic [LANES-1:0]     grp_used;
  logic [LANE_W-1:0]    lane;
  logic                 lane_found;
  logic [BLK_W-1:0]     free_blk;
  logic [SIZE_W:0]      size_round;
  logic [HOP_W-1:0]     blocks;
  logic [HOP_W-1:0]     links;
  logic [HOP_W-1:0]     hops;

  assign slot_idx      = SLOT_W'(file_q);
  assign slot_in_range = (32'(file_q) < 32'(SLOT_COUNT));

  // lowest free slot
  always_comb begin
    free_slot       = '0;
    free_slot_found = 1'b0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!slot_valid_q[s]) begin
        free_slot       = SLOT_W'(s);
        free_slot_found = 1'b1;
      end
    end
  end

  // eight blocks per cycle; pad entries read as taken
  assign used_pad = ~PAD_COUNT'(~used_q);
  assign grp_used = used_pad[{grp_q, {LANE_W{1'b0}}} +: LANES];

  always_comb begin
    lane       = '0;
    lane_found = 1'b0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (!grp_used[l]) begin
        lane       = LANE_W'(l);
        lane_found = 1'b1;
      end
    end
  end

  assign free_blk = BLK_W'({grp_q, lane});

  assign size_round = {1'b0, size_q} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
  assign blocks     = HOP_W'(size_round >> OFS_W);
  assign links      = (blocks == '0) ? '0 : blocks - HOP_W'(1);
  assign hops       = HOP_W'(pos_q >> OFS_W);

  always_comb begin
    sts_o            = '0;
    sts_o.kind       = kind_q;
    sts_o.slot_ok    = slot_in_range && slot_valid_q[slot_idx];
    sts_o.slot_free  = free_slot_found;
    sts_o.scan_found = lane_found;
    sts_o.scan_last  = (grp_q == GRP_W'(GROUP_COUNT - 1));
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.cur_end    = end_q[cur_q];
    sts_o.cut_stop   = end_q[cur_q] || (cur_q == blk_q);
    sts_o.out_busy   = out_valid_q && !out_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      used_q       <= '0;
      end_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.alloc_commit) begin
        slot_valid_q[free_slot] <= 1'b1;
        used_q[free_blk]        <= 1'b1;
        end_q[free_blk]         <= 1'b1;
      end
      if (cmd_i.append) begin
        end_q[cur_q]     <= 1'b0;
        used_q[free_blk] <= 1'b1;
        end_q[free_blk]  <= 1'b1;
      end
      if (cmd_i.cut_free) begin
        used_q[cur_q] <= 1'b0;
        end_q[cur_q]  <= 1'b0;
      end
      if (cmd_i.cut_end) begin
        end_q[blk_q] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_tuser_i;
      file_q   <= in_tdata_i[FILE_W-1:0];
      size_q   <= in_tdata_i[FILE_W +: SIZE_W];
      pos_q    <= in_tdata_i[FILE_W + SIZE_W +: POS_W];
      data_q   <= in_tdata_i[FILE_W + SIZE_W + POS_W +: DATA_W];
      res_q    <= in_tdata_i[FILE_W-1:0];
      status_q <= STATUS_OK;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.cur_first) begin
      cur_q <= first_q[slot_idx];
    end
    if (cmd_i.cnt_links) begin
      cnt_q <= links;
    end
    if (cmd_i.cnt_hops) begin
      cnt_q <= hops;
    end
    if (cmd_i.scan_start) begin
      grp_q <= '0;
    end
    if (cmd_i.scan_step) begin
      grp_q <= grp_q + GRP_W'(1);
    end
    if (cmd_i.alloc_commit) begin
      first_q[free_slot] <= free_blk;
      res_q              <= FILE_W'(free_slot);
    end
    if (cmd_i.append) begin
      cur_q <= free_blk;
      cnt_q <= cnt_q - HOP_W'(1);
    end
    if (cmd_i.follow) begin
      cur_q <= link_rd_q;
      cnt_q <= cnt_q - HOP_W'(1);
    end
    if (cmd_i.cut_start) begin
      blk_q <= cur_q;
    end
    if (cmd_i.cut_hop) begin
      cur_q <= link_rd_q;
    end
    if (cmd_i.out_load) begin
      out_file_q   <= res_q;
      out_status_q <= status_q;
    end
  end

  // link memory: one write, one registered read at the current block
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      link_mem[cur_q] <= free_blk;
    end
    link_rd_q <= link_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_store) begin
      byte_mem[{cur_q, pos_q[OFS_W-1:0]}] <= data_q;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {{(OUT_TDATA_W - FILE_W - STATUS_W){1'b0}}, out_status_q, out_file_q};

endmodule
